>>> src/assert_macros.svh
// Assertion macros used by the checker file kvt_checker.sv.
// No dependencies; each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same edge.
`define KVT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked on the next edge.
`define KVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/kvt_pkg.sv
// Shared constants, command codes and inter-module structs of the key/value table.
// No dependencies.
package kvt_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int KEY_BITS_DEF    = 32;
    localparam int VALUE_BITS_DEF  = 32;

    localparam int DATA_W      = 32;
    localparam int POS_W       = 8;
    localparam int CMD_W       = 3;
    localparam int COUNT_W     = 9;
    localparam int CELL_ENTRIES = 16;
    localparam int IDX_MAX_W   = 12;
    localparam int COUNT_MAX_W = 13;

    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UPSERT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ERASE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ_AT = 3'd5;

    // Request broadcast to every cell during a scan.
    typedef struct packed {
        logic [DATA_W-1:0]      key;
        logic [COUNT_MAX_W-1:0] count;
        logic [IDX_MAX_W-1:0]   sel_idx;
    } req_t;

    // Write broadcast to every cell; the entry at idx takes it.
    typedef struct packed {
        logic                  en;
        logic                  key_en;
        logic [IDX_MAX_W-1:0]  idx;
        logic [DATA_W-1:0]     key;
        logic [DATA_W-1:0]     value;
    } wr_t;

    // Word handed from cell to cell: key-match lane and position-select lane.
    typedef struct packed {
        logic                  hit;
        logic [IDX_MAX_W-1:0]  hit_idx;
        logic [DATA_W-1:0]     hit_value;
        logic [DATA_W-1:0]     sel_key;
        logic [DATA_W-1:0]     sel_value;
    } scan_bus_t;

endpackage

>>> src/kvt_cell.sv
// One cell of the table: a group of entries, their compares, and one stage of the scan bus.
// Depends on kvt_pkg.
module kvt_cell #(
    parameter int MAX_ENTRIES = kvt_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = kvt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = kvt_pkg::VALUE_BITS_DEF,
    parameter int CELL_BASE   = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  kvt_pkg::req_t     req,
    input  kvt_pkg::wr_t      wr,
    input  kvt_pkg::scan_bus_t bus_in,
    output kvt_pkg::scan_bus_t bus_out
);

    localparam int G     = kvt_pkg::CELL_ENTRIES;
    localparam int KEY_W = (KEY_BITS < kvt_pkg::DATA_W) ? KEY_BITS : kvt_pkg::DATA_W;
    localparam int VAL_W = (VALUE_BITS < kvt_pkg::DATA_W) ? VALUE_BITS : kvt_pkg::DATA_W;

    logic [G-1:0]                e_hit;
    logic [G-1:0]                e_sel;
    logic [kvt_pkg::DATA_W-1:0]  e_key [G];
    logic [kvt_pkg::DATA_W-1:0]  e_val [G];

    kvt_pkg::scan_bus_t bus_out_reg;
    kvt_pkg::scan_bus_t bus_out_next;

    for (genvar j = 0; j < G; j++)
    begin : g_entry
        if (CELL_BASE + j < MAX_ENTRIES)
        begin : g_used
            localparam logic [kvt_pkg::IDX_MAX_W-1:0] ENT_IDX =
                kvt_pkg::IDX_MAX_W'(CELL_BASE + j);

            logic [KEY_W-1:0] key_reg;
            logic [VAL_W-1:0] value_reg;

            always_ff @(posedge clk)
            begin
                if (wr.en && (wr.idx == ENT_IDX))
                begin
                    if (wr.key_en)
                    begin
                        key_reg <= wr.key[KEY_W-1:0];
                    end
                    value_reg <= wr.value[VAL_W-1:0];
                end
            end

            assign e_hit[j] = (key_reg == req.key[KEY_W-1:0]) &&
                              (kvt_pkg::COUNT_MAX_W'(ENT_IDX) < req.count);
            assign e_sel[j] = (ENT_IDX == req.sel_idx);
            assign e_key[j] = kvt_pkg::DATA_W'(key_reg);
            assign e_val[j] = kvt_pkg::DATA_W'(value_reg);
        end
        else
        begin : g_unused
            assign e_hit[j] = 1'b0;
            assign e_sel[j] = 1'b0;
            assign e_key[j] = '0;
            assign e_val[j] = '0;
        end
    end

    // Keys are unique, so at most one entry hits; OR-merge into the passing word.
    always_comb
    begin
        bus_out_next = bus_in;
        for (int j = 0; j < G; j++)
        begin
            if (e_hit[j])
            begin
                bus_out_next.hit       = 1'b1;
                bus_out_next.hit_idx   = bus_out_next.hit_idx |
                                         kvt_pkg::IDX_MAX_W'(CELL_BASE + j);
                bus_out_next.hit_value = bus_out_next.hit_value | e_val[j];
            end
            if (e_sel[j])
            begin
                bus_out_next.sel_key   = bus_out_next.sel_key | e_key[j];
                bus_out_next.sel_value = bus_out_next.sel_value | e_val[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_out_reg <= '0;
        end
        else
        begin
            bus_out_reg <= bus_out_next;
        end
    end

    assign bus_out = bus_out_reg;

endmodule

>>> src/kvt_ctrl.sv
// Sequencer of the table: takes a request, waits out the scan, applies the write, reports.
// Depends on kvt_pkg.
module kvt_ctrl #(
    parameter int MAX_ENTRIES = kvt_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = kvt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = kvt_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [kvt_pkg::CMD_W-1:0]     cmd,
    input  logic [kvt_pkg::DATA_W-1:0]    req_key,
    input  logic [kvt_pkg::DATA_W-1:0]    req_value,
    input  logic [kvt_pkg::POS_W-1:0]     position,
    output logic                          done,
    output logic                          ok,
    output logic [kvt_pkg::DATA_W-1:0]    found_key,
    output logic [kvt_pkg::DATA_W-1:0]    found_value,
    output logic [kvt_pkg::COUNT_W-1:0]   entry_count,
    output kvt_pkg::req_t                 req,
    output kvt_pkg::wr_t                  wr,
    input  kvt_pkg::scan_bus_t            bus_last
);

    localparam int KEY_W     = (KEY_BITS < kvt_pkg::DATA_W) ? KEY_BITS : kvt_pkg::DATA_W;
    localparam int VAL_W     = (VALUE_BITS < kvt_pkg::DATA_W) ? VALUE_BITS : kvt_pkg::DATA_W;
    localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int NUM_CELLS = (MAX_ENTRIES + kvt_pkg::CELL_ENTRIES - 1) /
                               kvt_pkg::CELL_ENTRIES;
    localparam int SCAN_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY} state_t;

    state_t                        state_reg, state_next;
    logic [SCAN_W-1:0]             scan_cnt_reg, scan_cnt_next;
    logic [kvt_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic [KEY_W-1:0]              key_reg, key_next;
    logic [VAL_W-1:0]              value_reg, value_next;
    logic [kvt_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          done_reg, done_next;
    logic                          ok_reg, ok_next;
    logic [kvt_pkg::DATA_W-1:0]    fkey_reg, fkey_next;
    logic [kvt_pkg::DATA_W-1:0]    fval_reg, fval_next;

    logic                          full;
    logic                          pos_ok;
    logic [kvt_pkg::IDX_MAX_W-1:0] last_idx;
    logic [kvt_pkg::IDX_MAX_W-1:0] tail_idx;
    logic                          ap_ok;
    logic [kvt_pkg::DATA_W-1:0]    ap_fkey;
    logic [kvt_pkg::DATA_W-1:0]    ap_fval;
    logic [CNT_W-1:0]              ap_count;
    kvt_pkg::wr_t                  ap_wr;

    assign full     = (count_reg == CNT_W'(MAX_ENTRIES));
    assign pos_ok   = kvt_pkg::COUNT_MAX_W'(pos_reg) < kvt_pkg::COUNT_MAX_W'(count_reg);
    assign last_idx = kvt_pkg::IDX_MAX_W'(count_reg - 1'b1);
    assign tail_idx = kvt_pkg::IDX_MAX_W'(count_reg);

    assign req.key     = kvt_pkg::DATA_W'(key_reg);
    assign req.count   = kvt_pkg::COUNT_MAX_W'(count_reg);
    assign req.sel_idx = (cmd_reg == kvt_pkg::CMD_ERASE) ? last_idx
                                                         : kvt_pkg::IDX_MAX_W'(pos_reg);

    // Outcome of the finished scan
    always_comb
    begin
        ap_ok    = 1'b0;
        ap_fkey  = '0;
        ap_fval  = '0;
        ap_count = count_reg;
        ap_wr    = '0;
        unique case (cmd_reg)
            kvt_pkg::CMD_INSERT:
            begin
                if (!bus_last.hit && !full)
                begin
                    ap_ok        = 1'b1;
                    ap_wr.en     = 1'b1;
                    ap_wr.key_en = 1'b1;
                    ap_wr.idx    = tail_idx;
                    ap_wr.key    = kvt_pkg::DATA_W'(key_reg);
                    ap_wr.value  = kvt_pkg::DATA_W'(value_reg);
                    ap_count     = count_reg + 1'b1;
                end
            end
            kvt_pkg::CMD_UPDATE:
            begin
                if (bus_last.hit)
                begin
                    ap_ok       = 1'b1;
                    ap_wr.en    = 1'b1;
                    ap_wr.idx   = bus_last.hit_idx;
                    ap_wr.value = kvt_pkg::DATA_W'(value_reg);
                end
            end
            kvt_pkg::CMD_UPSERT:
            begin
                if (bus_last.hit)
                begin
                    ap_ok       = 1'b1;
                    ap_wr.en    = 1'b1;
                    ap_wr.idx   = bus_last.hit_idx;
                    ap_wr.value = kvt_pkg::DATA_W'(value_reg);
                end
                else if (!full)
                begin
                    ap_ok        = 1'b1;
                    ap_wr.en     = 1'b1;
                    ap_wr.key_en = 1'b1;
                    ap_wr.idx    = tail_idx;
                    ap_wr.key    = kvt_pkg::DATA_W'(key_reg);
                    ap_wr.value  = kvt_pkg::DATA_W'(value_reg);
                    ap_count     = count_reg + 1'b1;
                end
            end
            kvt_pkg::CMD_ERASE:
            begin
                // last pair fills the hole
                if (bus_last.hit)
                begin
                    ap_ok        = 1'b1;
                    ap_wr.en     = 1'b1;
                    ap_wr.key_en = 1'b1;
                    ap_wr.idx    = bus_last.hit_idx;
                    ap_wr.key    = bus_last.sel_key;
                    ap_wr.value  = bus_last.sel_value;
                    ap_count     = count_reg - 1'b1;
                end
            end
            kvt_pkg::CMD_LOOKUP:
            begin
                if (bus_last.hit)
                begin
                    ap_ok   = 1'b1;
                    ap_fval = bus_last.hit_value;
                end
            end
            kvt_pkg::CMD_READ_AT:
            begin
                if (pos_ok)
                begin
                    ap_ok   = 1'b1;
                    ap_fkey = bus_last.sel_key;
                    ap_fval = bus_last.sel_value;
                end
            end
            default:
            begin
                ap_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        value_next    = value_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        done_next     = 1'b0;
        ok_next       = ok_reg;
        fkey_next     = fkey_reg;
        fval_next     = fval_reg;
        wr            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next      = cmd;
                    key_next      = req_key[KEY_W-1:0];
                    value_next    = req_value[VAL_W-1:0];
                    pos_next      = position;
                    scan_cnt_next = SCAN_W'(NUM_CELLS - 1);
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_cnt_reg == '0)
                begin
                    state_next = S_APPLY;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg - 1'b1;
                end
            end
            S_APPLY:
            begin
                wr         = ap_wr;
                ok_next    = ap_ok;
                fkey_next  = ap_fkey;
                fval_next  = ap_fval;
                count_next = ap_count;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_cnt_reg <= '0;
            cmd_reg      <= '0;
            key_reg      <= '0;
            value_reg    <= '0;
            pos_reg      <= '0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            ok_reg       <= 1'b0;
            fkey_reg     <= '0;
            fval_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            cmd_reg      <= cmd_next;
            key_reg      <= key_next;
            value_reg    <= value_next;
            pos_reg      <= pos_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
            ok_reg       <= ok_next;
            fkey_reg     <= fkey_next;
            fval_reg     <= fval_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign ok          = ok_reg;
    assign found_key   = fkey_reg;
    assign found_value = fval_reg;
    assign entry_count = kvt_pkg::COUNT_W'(count_reg);

endmodule

>>> src/key_value_table_core.sv
// Top level of the key/value table: sequencer plus the chain of entry cells.
// Depends on kvt_pkg, kvt_cell, kvt_ctrl.
//
//  channel   handshake         word
//  request   start / busy      cmd, req_key, req_value, position
//  result    done (strobe)     ok, found_key, found_value, entry_count
//
// A request is taken when start is high and busy is low. The scan word passes one cell of
// 16 entries per cycle; the sequencer holds in S_SCAN until it leaves the last cell, and
// S_APPLY then writes and registers done. A new request can be taken while done is shown.
// rst_n clears the count and the sequencer; entry storage has no reset.
// done is shown for one cycle only; the receiver cannot hold it off.
module key_value_table_core #(
    parameter int MAX_ENTRIES = kvt_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = kvt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = kvt_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [kvt_pkg::CMD_W-1:0]     cmd,
    input  logic [kvt_pkg::DATA_W-1:0]    req_key,
    input  logic [kvt_pkg::DATA_W-1:0]    req_value,
    input  logic [kvt_pkg::POS_W-1:0]     position,
    output logic                          done,
    output logic                          ok,
    output logic [kvt_pkg::DATA_W-1:0]    found_key,
    output logic [kvt_pkg::DATA_W-1:0]    found_value,
    output logic [kvt_pkg::COUNT_W-1:0]   entry_count
);

    localparam int NUM_CELLS = (MAX_ENTRIES + kvt_pkg::CELL_ENTRIES - 1) /
                               kvt_pkg::CELL_ENTRIES;

    kvt_pkg::req_t      req;
    kvt_pkg::wr_t       wr;
    kvt_pkg::scan_bus_t bus [NUM_CELLS+1];

    assign bus[0] = '0;

    kvt_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .req_key     (req_key),
        .req_value   (req_value),
        .position    (position),
        .done        (done),
        .ok          (ok),
        .found_key   (found_key),
        .found_value (found_value),
        .entry_count (entry_count),
        .req         (req),
        .wr          (wr),
        .bus_last    (bus[NUM_CELLS])
    );

    for (genvar c = 0; c < NUM_CELLS; c++)
    begin : g_cell
        kvt_cell #(
            .MAX_ENTRIES (MAX_ENTRIES),
            .KEY_BITS    (KEY_BITS),
            .VALUE_BITS  (VALUE_BITS),
            .CELL_BASE   (c * kvt_pkg::CELL_ENTRIES)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .req     (req),
            .wr      (wr),
            .bus_in  (bus[c]),
            .bus_out (bus[c+1])
        );
    end

endmodule

>>> src/kvt_checker.sv
// Port-level checks of key_value_table_core, bound to the top level.
// Depends on kvt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kvt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic                          ok,
    input logic [kvt_pkg::DATA_W-1:0]    found_key,
    input logic [kvt_pkg::DATA_W-1:0]    found_value,
    input logic [kvt_pkg::COUNT_W-1:0]   entry_count
);

    `KVT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    `KVT_ASSERT_IMP(a_done_after_busy, done, $past(busy) && !busy, "done without a request")
    `KVT_ASSERT_IMP(a_count_on_done, !done, $stable(entry_count), "count moved without done")
    `KVT_ASSERT_IMP(a_fail_zero, done && !ok, found_key == '0 && found_value == '0, "failed word carries data")

endmodule

bind key_value_table_core kvt_checker u_kvt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .ok          (ok),
    .found_key   (found_key),
    .found_value (found_value),
    .entry_count (entry_count)
);
